// ===== hw/rtl/ufl_pkg.sv =====
// shared types, constants and lookup functions for the utf-8 accent fold block
package ufl_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] FOLD_LEAD   = 8'hC3;
  localparam logic [7:0] UPPER_FIRST = 8'h41;
  localparam logic [7:0] UPPER_LAST  = 8'h5A;
  localparam logic [7:0] CASE_DELTA  = 8'h20;
  localparam logic [7:0] NO_FOLD     = 8'h00;

  localparam logic [2:0] LEN_ONE = 3'd1;
  localparam logic [2:0] LEN_TWO = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR = 3'd4;

  // one output byte with its end-of-string mark
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } ufl_byte_t;

  // up to two output bytes made from one input item
  typedef struct packed {
    logic [1:0] count;
    ufl_byte_t  first;
    ufl_byte_t  second;
  } ufl_result_t;

  // character length from the lead byte's high nibble
  function automatic logic [2:0] char_len(input logic [3:0] nibble);
    logic [2:0] len;
    case (nibble)
      4'hC, 4'hD: len = LEN_TWO;
      4'hE:       len = LEN_THREE;
      4'hF:       len = LEN_FOUR;
      default:    len = LEN_ONE;
    endcase
    return len;
  endfunction

  // lowercase ascii letter for the low five bits of a second byte after 0xc3
  function automatic logic [7:0] fold_letter(input logic [4:0] idx);
    logic [7:0] f;
    case (idx)
      5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5:     f = 8'h61; // a
      5'd7:                                  f = 8'h63; // c
      5'd8, 5'd9, 5'd10, 5'd11:              f = 8'h65; // e
      5'd12, 5'd13, 5'd14, 5'd15:            f = 8'h69; // i
      5'd17:                                 f = 8'h6E; // n
      5'd18, 5'd19, 5'd20, 5'd21, 5'd22:     f = 8'h6F; // o
      5'd25, 5'd26, 5'd27, 5'd28:            f = 8'h75; // u
      5'd29:                                 f = 8'h79; // y
      default:                               f = NO_FOLD;
    endcase
    return f;
  endfunction

endpackage

// ===== hw/rtl/ufl_fold.sv =====
// character tracking state and fold/lowercase logic for one byte
module ufl_fold (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  output ufl_pkg::ufl_result_t result
);

  logic       lead_pending, lead_pending_next;
  logic [7:0] held_lead, held_lead_next;
  logic [1:0] span_left, span_left_next;
  logic [7:0] folded;
  logic [2:0] len;
  logic [2:0] len_less;

  always_comb begin
    folded = ufl_pkg::NO_FOLD;
    if (held_lead == ufl_pkg::FOLD_LEAD && in_byte[7:6] == 2'b10) begin
      folded = ufl_pkg::fold_letter(in_byte[4:0]);
    end
    len      = ufl_pkg::char_len(in_byte[7:4]);
    len_less = len - 3'd1;

    lead_pending_next = lead_pending;
    held_lead_next    = held_lead;
    span_left_next    = span_left;
    result            = '0;
    result.first.data = in_byte;
    result.first.last = in_last;
    result.second.data = in_byte;
    result.second.last = in_last;

    if (lead_pending) begin
      if (folded != ufl_pkg::NO_FOLD) begin
        result.count      = 2'd1;
        result.first.data = folded;
      end else begin
        result.count      = 2'd2;
        result.first.data = held_lead;
        result.first.last = 1'b0;
      end
      lead_pending_next = 1'b0;
      held_lead_next    = 8'h00;
    end else if (span_left != 2'd0) begin
      result.count   = 2'd1;
      span_left_next = span_left - 2'd1;
    end else if (len == ufl_pkg::LEN_ONE) begin
      result.count = 2'd1;
      if (in_byte >= ufl_pkg::UPPER_FIRST && in_byte <= ufl_pkg::UPPER_LAST) begin
        result.first.data = in_byte + ufl_pkg::CASE_DELTA;
      end
    end else if (len == ufl_pkg::LEN_TWO) begin
      if (in_last) begin
        result.count = 2'd1;
      end else begin
        result.count      = 2'd0;
        lead_pending_next = 1'b1;
        held_lead_next    = in_byte;
      end
    end else begin
      result.count   = 2'd1;
      span_left_next = len_less[1:0];
    end

    if (in_last) begin
      lead_pending_next = 1'b0;
      held_lead_next    = 8'h00;
      span_left_next    = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_pending <= 1'b0;
      held_lead    <= 8'h00;
      span_left    <= 2'd0;
    end else if (fire) begin
      lead_pending <= lead_pending_next;
      held_lead    <= held_lead_next;
      span_left    <= span_left_next;
    end
  end

endmodule

// ===== hw/rtl/ufl_out_queue.sv =====
// small output queue, takes up to two bytes per cycle and gives one per cycle while out_ready is high
module ufl_out_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ufl_pkg::ufl_result_t result,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ufl_pkg::ufl_byte_t   out_item
);

  ufl_pkg::ufl_byte_t              mem [ufl_pkg::QDEPTH];
  logic [ufl_pkg::QPTR_W-1:0]      wr_ptr, rd_ptr;
  logic [ufl_pkg::QCNT_W-1:0]      count, count_next;
  logic [1:0]                      n_push;
  logic                            pop;

  assign n_push    = push ? result.count : 2'd0;
  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign out_item  = mem[rd_ptr];
  // room for a worst-case item of two bytes
  assign room      = (count <= ufl_pkg::QCNT_W'(ufl_pkg::QDEPTH - 2));

  always_comb begin
    count_next = count + ufl_pkg::QCNT_W'(n_push) - ufl_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wr_ptr] <= result.first;
    end
    if (n_push == 2'd2) begin
      mem[wr_ptr + ufl_pkg::QPTR_W'(1)] <= result.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + ufl_pkg::QPTR_W'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + ufl_pkg::QPTR_W'(1);
      end
      count <= count_next;
    end
  end

endmodule

// ===== hw/rtl/utf8_accent_fold_lowercase.sv =====
// top level: utf-8 accent fold and ascii lowercase stream stage
// path: an item is held in the input register, then its bytes are written into the output queue,
//   from which they leave; a held two-byte lead leaves with its pair
// throughput: one input item per cycle, one output item per cycle; an item is processed
//   when the four-entry output queue has room for two bytes, the queue drain sets the pace
// reset: rst is synchronous, active high; clears the input valid flag, the character state
//   and the queue pointers, no clearing pass
module utf8_accent_fold_lowercase (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // in_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast    // out_last
);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  logic                 fire;
  logic                 room;
  ufl_pkg::ufl_result_t result;
  ufl_pkg::ufl_byte_t   out_item;

  // the held item is processed once the queue can take both of its bytes
  assign fire          = in_valid && room;
  assign s_axis_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  // character state and per-byte fold
  ufl_fold u_fold (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .in_byte (in_byte),
    .in_last (in_last),
    .result  (result)
  );

  // output side, decouples two-byte bursts from the one-per-cycle drain, held off while m_axis_tready is low
  ufl_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .result    (result),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_item  (out_item)
  );

  assign m_axis_tdata = out_item.data;
  assign m_axis_tlast = out_item.last;

endmodule
